// ===== rtl/dadd_pkg.sv =====
// Shared types, constants and calendar functions for the date adder.
// Used by dadd_ctrl, dadd_dp and date_add_days; depends on nothing else.
package dadd_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int YEAR_W   = 16;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;
  localparam int SHIFT_W  = 3;
  localparam int CYC_W    = 9;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;

  localparam logic [YEAR_W-1:0]  MAX_YEAR   = 16'hFFFF;
  localparam logic [YEAR_W-1:0]  YEAR_CYCLE = 16'd400;
  localparam logic [CYC_W-1:0]   CYCLE_LAST = 9'd399;
  localparam logic [SHIFT_W-1:0] SHIFT_TOP  = 3'd7;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [LEN_W-1:0] LEN_LONG     = 5'd31;
  localparam logic [LEN_W-1:0] LEN_SHORT    = 5'd30;
  localparam logic [LEN_W-1:0] LEN_FEB      = 5'd28;
  localparam logic [LEN_W-1:0] LEN_FEB_LEAP = 5'd29;
  localparam logic [LEN_W-1:0] LEN_NONE     = 5'd0;

  typedef struct packed {
    logic               load;
    logic               reduce;
    logic [SHIFT_W-1:0] shift;
    logic               set_inval;
    logic               walk;
    logic               add;
    logic               norm;
    logic               set_ovf;
    logic               ld_out;
  } dadd_cmd_t;

  typedef struct packed {
    logic inval;
    logic rest_ge_len;
    logic day_gt_len;
    logic carry_ovf;
  } dadd_stat_t;

  // r is the year modulo 400
  function automatic logic is_leap(input logic [CYC_W-1:0] r);
    return (r == '0) ||
           ((r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300));
  endfunction

  function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [LEN_W-1:0] len;
    case (m)
      MONTH_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, MONTH_DEC: len = LEN_LONG;
      default: len = LEN_NONE;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/dadd_dp.sv =====
// Datapath of the date adder: working date, remaining count, year-mod-400
// counter, status and result register. Depends on dadd_pkg.
module dadd_dp #(
  parameter int OFFSET_BITS = dadd_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  dadd_pkg::dadd_cmd_t            cmd,
  output dadd_pkg::dadd_stat_t           stat,
  input  logic [dadd_pkg::YEAR_W-1:0]    in_start_year,
  input  logic [dadd_pkg::MONTH_W-1:0]   in_start_month,
  input  logic [dadd_pkg::DAY_W-1:0]     in_start_day,
  input  logic [OFFSET_BITS-1:0]         in_day_offset,
  output logic [dadd_pkg::YEAR_W-1:0]    out_end_year,
  output logic [dadd_pkg::MONTH_W-1:0]   out_end_month,
  output logic [dadd_pkg::DAY_W-1:0]     out_end_day,
  output logic [dadd_pkg::STATUS_W-1:0]  out_status
);
  import dadd_pkg::*;

  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [MONTH_W-1:0]  month_r, month_nxt;
  logic [DAY_W:0]      day_r, day_nxt;
  logic [OFFSET_BITS-1:0] rest_r, rest_nxt;
  logic [YEAR_W-1:0]   scr_r, scr_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic [YEAR_W-1:0]   out_year_r, out_year_nxt;
  logic [MONTH_W-1:0]  out_month_r, out_month_nxt;
  logic [DAY_W-1:0]    out_day_r, out_day_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [LEN_W-1:0]    len;
  logic [YEAR_W-1:0]   sub;
  logic                dec_month;
  logic [MONTH_W-1:0]  month_inc;
  logic [YEAR_W-1:0]   scr_inc;

  assign len       = month_len(month_r, is_leap(scr_r[CYC_W-1:0]));
  assign sub       = YEAR_CYCLE << cmd.shift;
  assign dec_month = (month_r == MONTH_DEC);
  assign month_inc = dec_month ? MONTH_JAN : month_r + 1'b1;
  assign scr_inc   = (scr_r[CYC_W-1:0] == CYCLE_LAST) ? '0 : scr_r + 1'b1;

  assign stat.inval       = (len == LEN_NONE) || (day_r == '0) ||
                            (day_r > {1'b0, len});
  assign stat.rest_ge_len = (rest_r >= OFFSET_BITS'(len));
  assign stat.day_gt_len  = (day_r > {1'b0, len});
  assign stat.carry_ovf   = dec_month && (year_r == MAX_YEAR);

  always_comb begin
    year_nxt       = year_r;
    month_nxt      = month_r;
    day_nxt        = day_r;
    rest_nxt       = rest_r;
    scr_nxt        = scr_r;
    status_nxt     = status_r;
    out_year_nxt   = out_year_r;
    out_month_nxt  = out_month_r;
    out_day_nxt    = out_day_r;
    out_status_nxt = out_status_r;
    if (cmd.load) begin
      year_nxt   = in_start_year;
      month_nxt  = in_start_month;
      day_nxt    = {1'b0, in_start_day};
      rest_nxt   = in_day_offset;
      scr_nxt    = in_start_year;
      status_nxt = STAT_OK;
    end
    // conditional subtract of 400 << shift, leaving year mod 400
    if (cmd.reduce && (scr_r >= sub)) begin
      scr_nxt = scr_r - sub;
    end
    if (cmd.walk || cmd.norm) begin
      month_nxt = month_inc;
      if (dec_month) begin
        year_nxt = year_r + 1'b1;
        scr_nxt  = scr_inc;
      end
    end
    if (cmd.walk) begin
      rest_nxt = rest_r - OFFSET_BITS'(len);
    end
    if (cmd.add) begin
      day_nxt = day_r + {1'b0, rest_r[DAY_W-1:0]};
    end
    if (cmd.norm) begin
      day_nxt = day_r - {1'b0, len};
    end
    if (cmd.set_inval) begin
      status_nxt = STAT_INVALID;
    end
    if (cmd.set_ovf) begin
      status_nxt = STAT_OVERFLOW;
    end
    if (cmd.ld_out) begin
      out_status_nxt = status_r;
      if (status_r == STAT_OK) begin
        out_year_nxt  = year_r;
        out_month_nxt = month_r;
        out_day_nxt   = day_r[DAY_W-1:0];
      end else begin
        out_year_nxt  = '0;
        out_month_nxt = '0;
        out_day_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    year_r       <= year_nxt;
    month_r      <= month_nxt;
    day_r        <= day_nxt;
    rest_r       <= rest_nxt;
    scr_r        <= scr_nxt;
    status_r     <= status_nxt;
    out_year_r   <= out_year_nxt;
    out_month_r  <= out_month_nxt;
    out_day_r    <= out_day_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_end_year  = out_year_r;
  assign out_end_month = out_month_r;
  assign out_end_day   = out_day_r;
  assign out_status    = out_status_r;

endmodule

// ===== rtl/dadd_ctrl.sv =====
// Controller of the date adder: sequences reduction, check, month walk,
// final normalisation and result hand-off. Depends on dadd_pkg.
module dadd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dadd_pkg::dadd_cmd_t  cmd,
  input  dadd_pkg::dadd_stat_t stat
);
  import dadd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_ADD    = 3'd4;
  localparam logic [2:0] ST_NORM   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [SHIFT_W-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.shift = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = SHIFT_TOP;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_CHECK;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_CHECK: begin
        if (stat.inval) begin
          cmd.set_inval = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!stat.rest_ge_len) begin
          state_nxt = ST_ADD;
        end else if (stat.carry_ovf) begin
          cmd.set_ovf = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (stat.day_gt_len) begin
          if (stat.carry_ovf) begin
            cmd.set_ovf = 1'b1;
          end else begin
            cmd.norm = 1'b1;
          end
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold the finished request until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.ld_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_REDUCE && cnt_r == SHIFT_TOP))
    else $error("accepted request did not start the year reduction");

  a_reduce_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REDUCE && cnt_r == '0) |=> (state_r == ST_CHECK))
    else $error("year reduction did not end in the check state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || out_ready))
    else $error("result register loaded while a result still waits");

  a_ld_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result load did not raise out_valid");
`endif

endmodule

// ===== rtl/date_add_days.sv =====
// Date adder: Gregorian date plus an unsigned day count, one request at a time.
// The controller reduces the year modulo 400, checks the start date, walks whole
// months (one month per cycle), adds the remainder and normalises once more.
// A new request is taken only after the last result is loaded; in_ready is high only when idle.
// Reset: rst_n synchronous, active low; clears the controller and out_valid only.
module date_add_days #(
  parameter int OFFSET_BITS = dadd_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dadd_pkg::YEAR_W-1:0]   in_start_year,
  input  logic [dadd_pkg::MONTH_W-1:0]  in_start_month,
  input  logic [dadd_pkg::DAY_W-1:0]    in_start_day,
  input  logic [OFFSET_BITS-1:0]        in_day_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dadd_pkg::YEAR_W-1:0]   out_end_year,
  output logic [dadd_pkg::MONTH_W-1:0]  out_end_month,
  output logic [dadd_pkg::DAY_W-1:0]    out_end_day,
  output logic [dadd_pkg::STATUS_W-1:0] out_status
);
  import dadd_pkg::*;

  dadd_cmd_t  cmd;
  dadd_stat_t stat;

  dadd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  dadd_dp #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .stat           (stat),
    .in_start_year  (in_start_year),
    .in_start_month (in_start_month),
    .in_start_day   (in_start_day),
    .in_day_offset  (in_day_offset),
    .out_end_year   (out_end_year),
    .out_end_month  (out_end_month),
    .out_end_day    (out_end_day),
    .out_status     (out_status)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for date_add_days: directed and random date requests,
// a predictor of the calendar walk, and random idling on both channels.
// Depends on rtl/dadd_pkg.sv and rtl/date_add_days.sv.
`timescale 1ns / 1ps

module tb;
  import dadd_pkg::*;

  localparam int OFF_W       = OFFSET_BITS_DEF;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RANDOM_REQS = 250;
  localparam int QUIET_TAIL  = 30;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [OFF_W-1:0]   offset;
    bit                 drain;
  } date_req_t;

  typedef struct {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [STATUS_W-1:0] status;
  } date_res_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [YEAR_W-1:0]   in_start_year  = '0;
  logic [MONTH_W-1:0]  in_start_month = '0;
  logic [DAY_W-1:0]    in_start_day   = '0;
  logic [OFF_W-1:0]    in_day_offset  = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [YEAR_W-1:0]   out_end_year;
  logic [MONTH_W-1:0]  out_end_month;
  logic [DAY_W-1:0]    out_end_day;
  logic [STATUS_W-1:0] out_status;

  date_req_t date_reqs[$];
  date_res_t expected_dates[$];
  date_req_t live_req;

  int n_total    = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_cycles   = 0;
  int gap_left   = 0;
  int idle_pct   = 0;
  int stall_left = 0;
  int stall_pct  = 0;

  always #2 clk = ~clk;

  date_add_days #(.OFFSET_BITS(OFF_W)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_year  (in_start_year),
    .in_start_month (in_start_month),
    .in_start_day   (in_start_day),
    .in_day_offset  (in_day_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_end_year   (out_end_year),
    .out_end_month  (out_end_month),
    .out_end_day    (out_end_day),
    .out_status     (out_status)
  );

  function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
    bit leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    case (m)
      2:                       return leap ? 29 : 28;
      4, 6, 9, 11:             return 30;
      1, 3, 5, 7, 8, 10, 12:   return 31;
      default:                 return 0;
    endcase
  endfunction

  // Walk whole months, then add the remainder and normalise one more month
  function automatic date_res_t add_days(input date_req_t r);
    date_res_t           res;
    int unsigned         y, m, d, rest, len;
    logic [STATUS_W-1:0] st;
    y    = r.year;
    m    = r.month;
    d    = r.day;
    rest = r.offset;
    st   = STAT_OK;
    len  = days_in(y, m);
    if (len == 0 || d == 0 || d > len) begin
      st = STAT_INVALID;
    end else begin
      while (st == STAT_OK && rest >= len) begin
        rest = rest - len;
        m++;
        if (m > 12) begin
          m = 1;
          if (y == MAX_YEAR) st = STAT_OVERFLOW;
          else y++;
        end
        len = days_in(y, m);
      end
      if (st == STAT_OK) begin
        d = d + rest;
        if (d > len) begin
          d = d - len;
          m++;
          if (m > 12) begin
            m = 1;
            if (y == MAX_YEAR) st = STAT_OVERFLOW;
            else y++;
          end
        end
      end
    end
    if (st != STAT_OK) begin
      y = 0;
      m = 0;
      d = 0;
    end
    res.year   = y[YEAR_W-1:0];
    res.month  = m[MONTH_W-1:0];
    res.day    = d[DAY_W-1:0];
    res.status = st;
    return res;
  endfunction

  function automatic date_req_t random_req();
    date_req_t   r;
    int unsigned y, m, len, pick, tmp;
    pick = $urandom_range(0, 3);
    case (pick)
      0:       y = $urandom_range(0, 65535);
      1:       y = $urandom_range(65500, 65535);
      2:       y = $urandom_range(0, 655) * 100;
      default: y = $urandom_range(1, 3000);
    endcase
    m = $urandom_range(1, 12);
    if (pick == 2 && $urandom_range(0, 1) == 0) m = 2;
    len = days_in(y, m);
    r.year  = y[YEAR_W-1:0];
    r.month = m[MONTH_W-1:0];
    // favour month ends, where the final normalisation kicks in
    if ($urandom_range(0, 9) < 3) tmp = len - $urandom_range(0, 1);
    else tmp = $urandom_range(1, len);
    r.day = tmp[DAY_W-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 60) tmp = $urandom_range(0, 1200);
    else if (pick < 80) tmp = $urandom_range(0, 62);
    else tmp = $urandom();
    r.offset = tmp[OFF_W-1:0];
    if ($urandom_range(0, 9) == 0) begin
      tmp = $urandom();
      r.month = tmp[MONTH_W-1:0];
      r.day   = tmp[MONTH_W +: DAY_W];
    end
    r.drain = 1'b0;
    return r;
  endfunction

  task automatic add_req(input int unsigned y, input int unsigned m, input int unsigned d,
                         input int unsigned off, input bit drain);
    date_req_t r;
    r.year   = y[YEAR_W-1:0];
    r.month  = m[MONTH_W-1:0];
    r.day    = d[DAY_W-1:0];
    r.offset = off[OFF_W-1:0];
    r.drain  = drain;
    date_reqs.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Driver: present the next request, with idle bursts between requests
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_dates.push_back(add_days(live_req));
        n_accepted++;
        if (n_accepted % 20 == 0) begin
          case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 20;
            default: idle_pct = 50;
          endcase
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (date_reqs.size() >= QUIET_TAIL &&
                     $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (date_reqs.size() > 0 &&
                     !(date_reqs[0].drain && expected_dates.size() != 0)) begin
          live_req = date_reqs.pop_front();
          in_valid       <= 1'b1;
          in_start_year  <= live_req.year;
          in_start_month <= live_req.month;
          in_start_day   <= live_req.day;
          in_day_offset  <= live_req.offset;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction; stall in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, got %0d-%0d-%0d status %0d",
                   $time, out_end_year, out_end_month, out_end_day, out_status);
        end else begin
          date_res_t want;
          want = expected_dates.pop_front();
          check_field("end_year", 16'(want.year), 16'(out_end_year));
          check_field("end_month", 16'(want.month), 16'(out_end_month));
          check_field("end_day", 16'(want.day), 16'(out_end_day));
          check_field("status", 16'(want.status), 16'(out_status));
          n_checked++;
          if (n_checked % 20 == 0) begin
            case ($urandom_range(0, 2))
              0:       stall_pct = 0;
              1:       stall_pct = 20;
              default: stall_pct = 50;
            endcase
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (n_checked + QUIET_TAIL < n_total &&
                   $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("** date_add_days: FAILED **");
      $finish;
    end
  end

  initial begin
    add_req(2024, 1, 1, 0, 1'b0);
    add_req(0, 2, 29, 0, 1'b0);           // year 0 counts as leap
    add_req(1900, 2, 29, 1, 1'b0);        // century, not leap
    add_req(2000, 2, 29, 365, 1'b0);
    add_req(2100, 2, 28, 1, 1'b0);
    add_req(2400, 2, 28, 1, 1'b0);
    add_req(2023, 1, 31, 31, 1'b0);       // day overruns the month reached
    add_req(2023, 12, 31, 1, 1'b0);
    add_req(0, 1, 1, 65535, 1'b0);
    add_req(65535, 12, 31, 0, 1'b0);
    add_req(65535, 12, 31, 1, 1'b1);      // carry out of the last year on normalising
    add_req(65535, 11, 15, 100, 1'b0);    // carry out of the last year in the walk
    add_req(65535, 1, 1, 65535, 1'b0);
    add_req(65488, 3, 31, 65535, 1'b0);
    add_req(2024, 0, 10, 5, 1'b0);
    add_req(2024, 13, 10, 5, 1'b0);
    add_req(2024, 15, 31, 65535, 1'b0);
    add_req(2024, 6, 0, 5, 1'b0);
    add_req(2024, 4, 31, 5, 1'b0);
    add_req(2024, 2, 30, 5, 1'b0);
    add_req(2025, 8, 31, 30, 1'b0);
    add_req(1999, 12, 31, 0, 1'b0);
    add_req(12345, 7, 17, 16'h5555, 1'b0);
    add_req(16'hAAAA, 10, 10, 16'hAAAA, 1'b0);
    for (int i = 0; i < RANDOM_REQS; i++) begin
      date_req_t r;
      r = random_req();
      // hold off until the block has drained
      if (i == RANDOM_REQS / 2) r.drain = 1'b1;
      date_reqs.push_back(r);
    end
    n_total = date_reqs.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (n_errors == 0) $display("** date_add_days: PASSED **");
    else $display("** date_add_days: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dadd_pkg.sv
rtl/dadd_dp.sv
rtl/dadd_ctrl.sv
rtl/date_add_days.sv
verif/tb.sv
